// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the slerp RTL
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion_slerp: check failed");

// next-cycle implication
`define QS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quaternion_slerp: check failed");

`endif

// ===== src/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg
// Types, widths and elaboration-time constant functions for quaternion_slerp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qs_pkg;

  localparam int FRAC_BITS = 14;               // Q2.14 fields
  localparam int IB        = 30;               // internal fraction bits
  localparam int XW        = 34;               // CORDIC x/y/z width
  localparam int SW        = 31;               // sqrt result width
  localparam int SQ_RW     = 35;               // sqrt remainder width
  localparam int QW        = 38;               // quotient magnitude bits
  localparam int KW        = QW + 1;           // signed weight width
  localparam int DIV_LAT   = QW + 2;           // divider latency
  localparam int PW        = 58;               // output product width

  typedef struct packed {
    logic signed [15:0] q0_w;
    logic signed [15:0] q0_x;
    logic signed [15:0] q0_y;
    logic signed [15:0] q0_z;
    logic signed [15:0] q1_w;
    logic signed [15:0] q1_x;
    logic signed [15:0] q1_y;
    logic signed [15:0] q1_z;
    logic signed [15:0] blend_t;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_t;

  // side band that travels with each request down the pipe
  typedef struct packed {
    logic          valid;
    logic          byp0;   // t not above zero
    logic          byp1;   // t at or above one
    logic          neg;    // dot product was negative
    logic          lin;    // linear weights
    in_t           q;
    logic [IB-1:0] c;      // cosine, Q.30
    logic [SW-1:0] s;      // sine of omega, Q.30
  } sb_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // atan(2^-i) in Q.30 by power series in Q.62, rounded
  function automatic logic [63:0] atan_q30(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = '0;
    if (i == 0) return 64'd843314857;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
    end
    return (acc + (64'd1 << 31)) >> 32;
  endfunction

  // inverse CORDIC gain in Q.30
  function automatic logic [63:0] inv_gain(input int steps);
    logic [63:0] p;
    logic [63:0] q;
    p = 64'd1 << IB;
    for (int i = 0; i < steps; i++) begin
      p = p + (p >> (2 * i));
    end
    q = udiv64(64'd1 << 62, p);
    return isqrt64(q << 28);
  endfunction

  function automatic logic signed [15:0] round_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + (PW'(1) <<< (IB - 1))) >>> IB;
    if (r > PW'(32767))  return 16'sh7fff;
    if (r < -PW'(32768)) return 16'sh8000;
    return r[15:0];
  endfunction

endpackage

// ===== src/qs_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// qs_cordic_rot
// Pipelined CORDIC rotation, one step per stage, returns the sine of angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qs_cordic_rot #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qs_pkg::XW-1:0]  angle,
  output logic signed [qs_pkg::XW-1:0]  sine
);

  localparam int W = qs_pkg::XW;
  localparam logic signed [W-1:0] GAIN = W'(qs_pkg::inv_gain(STEPS));

  logic signed [W-1:0] x [STEPS];
  logic signed [W-1:0] y [STEPS];
  logic signed [W-1:0] z [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic signed [W-1:0] AT = W'(qs_pkg::atan_q30(j));
    logic signed [W-1:0] xi, yi, zi;
    if (j == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = angle;
    end else begin : g_next
      assign xi = x[j-1];
      assign yi = y[j-1];
      assign zi = z[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          x[j] <= xi - (yi >>> j);
          y[j] <= yi + (xi >>> j);
          z[j] <= zi - AT;
        end else begin
          x[j] <= xi + (yi >>> j);
          y[j] <= yi - (xi >>> j);
          z[j] <= zi + AT;
        end
      end
    end
  end

  assign sine = y[STEPS-1];

endmodule

// ===== src/qs_div.sv =====
// ----------------------------------------------------------------------------
// qs_div
// Pipelined restoring divider: quo = num * 2^30 / den, truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qs_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qs_pkg::XW-1:0]  num,
  input  logic        [qs_pkg::SW-1:0]  den,
  output logic signed [qs_pkg::KW-1:0]  quo
);

  localparam int QW = qs_pkg::QW;
  localparam int RW = qs_pkg::XW + qs_pkg::IB;
  localparam int CW = RW + 8;

  logic          neg  [QW+1];
  logic [RW-1:0] rem  [QW+1];
  logic [qs_pkg::SW-1:0] dd [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [qs_pkg::XW-1:0] mag;

  assign mag = num[qs_pkg::XW-1] ? qs_pkg::XW'(-num) : qs_pkg::XW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= num[qs_pkg::XW-1];
      rem[0] <= {mag, qs_pkg::IB'(0)};
      dd[0]  <= den;
      q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int B = QW - 1 - j;
    logic [CW-1:0] sub;
    logic          take;
    assign sub  = CW'(dd[j]) << B;
    assign take = CW'(rem[j]) >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        neg[j+1] <= neg[j];
        dd[j+1]  <= dd[j];
        rem[j+1] <= take ? rem[j] - sub[RW-1:0] : rem[j];
        q[j+1]   <= {q[j][QW-2:0], take};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo <= neg[QW] ? -$signed({1'b0, q[QW]}) : $signed({1'b0, q[QW]});
  end

endmodule

// ===== src/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp
// Spherical linear interpolation of two unit quaternions, Q2.14, pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                    | payload
//  --------+----------------------------+--------------------------------
//  in      | in_valid, in_ready         | in_data  (q0, q1, blend_t)
//  out     | out_valid, out_ready       | out_data (out_w .. out_z)
//
//  One request enters per cycle while the pipe is not held; most of its depth
//  lies in the 31-stage square root, the two CORDIC chains and the 40-stage
//  divider.
//  Reset clears only the valid bits; the pipe holds as a whole while the
//  output register is full and not taken, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quaternion_slerp #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qs_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qs_pkg::out_t  out_data
);

  localparam int N        = CORDIC_STEPS;
  localparam int IB       = qs_pkg::IB;
  localparam int XW       = qs_pkg::XW;
  localparam int SW       = qs_pkg::SW;
  localparam int KW       = qs_pkg::KW;
  localparam int PW       = qs_pkg::PW;
  localparam int RW       = qs_pkg::SQ_RW;
  localparam int K_DOT    = 2;
  localparam int K_LIN    = 3;
  localparam int K_SQ_END = 4 + SW;
  localparam int K_V_END  = K_SQ_END + N;
  localparam int K_M2     = K_V_END + 2;
  localparam int K_R_END  = K_M2 + N;
  localparam int K_D_END  = K_R_END + qs_pkg::DIV_LAT;
  localparam int K_F1     = K_D_END + 1;
  localparam logic [63:0] ONE_T = 64'd1 << qs_pkg::FRAC_BITS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qs_pkg::sb_t sb [1:K_F1];

  // ---------------- dot product ----------------
  logic signed [31:0] prod [4];
  logic [34:0]        c2;
  logic signed [33:0] dot;
  logic [33:0]        dmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb[1].valid <= 1'b0;
    end else if (en) begin
      sb[1].valid <= in_valid;
      sb[1].byp0  <= in_data.blend_t <= 16'sd0;
      sb[1].byp1  <= 17'(in_data.blend_t) >= 17'(ONE_T);
      sb[1].neg   <= 1'b0;
      sb[1].lin   <= 1'b0;
      sb[1].q     <= in_data;
      sb[1].c     <= '0;
      sb[1].s     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= in_data.q0_w * in_data.q1_w;
      prod[1] <= in_data.q0_x * in_data.q1_x;
      prod[2] <= in_data.q0_y * in_data.q1_y;
      prod[3] <= in_data.q0_z * in_data.q1_z;
    end
  end

  assign dot  = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
  assign dmag = dot[33] ? 34'(-dot) : 34'(dot);

  always_ff @(posedge clk) begin
    if (en) c2 <= {dmag[32:0], 2'b00};
  end

  // ---------------- linear test, 1 - c^2 ----------------
  logic [59:0] cc3;
  logic [60:0] r4;
  logic        lin2;

  assign lin2 = 49'(c2) * 49'd10000 > 49'd9999 << IB;

  always_ff @(posedge clk) begin
    if (en) begin
      cc3 <= 60'(c2[IB-1:0]) * 60'(c2[IB-1:0]);
      r4  <= (61'd1 << 60) - 61'(cc3);
    end
  end

  // ---------------- side band delay line ----------------
  logic [SW-1:0] sq_root [SW];
  logic [RW-1:0] sq_rem  [SW];
  logic [61:0]   sq_v    [SW];

  for (genvar k = 2; k <= K_F1; k++) begin : g_sb
    qs_pkg::sb_t nxt;
    always_comb begin
      nxt = sb[k-1];
      if (k == K_DOT) begin
        nxt.neg = dot[33];
        nxt.c   = dmag[IB-3:0] << 2;
      end
      if (k == K_LIN) nxt.lin = lin2;
      if (k == K_SQ_END + 1) nxt.s = sq_root[SW-1];
    end
    always_ff @(posedge clk) begin
      if (rst) sb[k].valid <= 1'b0;
      else if (en) sb[k] <= nxt;
    end
  end

  // ---------------- square root, one result bit a stage ----------------
  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    localparam int B = SW - 1 - j;
    logic [RW-1:0] rin, rsh, trial;
    logic [SW-1:0] oin;
    logic [61:0]   vin;
    if (j == 0) begin : g_first
      assign rin = '0;
      assign oin = '0;
      assign vin = {1'b0, r4};
    end else begin : g_next
      assign rin = sq_rem[j-1];
      assign oin = sq_root[j-1];
      assign vin = sq_v[j-1];
    end
    assign rsh   = {rin[RW-3:0], vin[2*B+1:2*B]};
    assign trial = RW'({oin, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        sq_v[j] <= vin;
        if (rsh >= trial) begin
          sq_rem[j]  <= rsh - trial;
          sq_root[j] <= {oin[SW-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= rsh;
          sq_root[j] <= {oin[SW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- CORDIC vectoring: omega ----------------
  logic signed [XW-1:0] vx [N];
  logic signed [XW-1:0] vy [N];
  logic signed [XW-1:0] vz [N];

  for (genvar j = 0; j < N; j++) begin : g_vec
    localparam logic signed [XW-1:0] AT = XW'(qs_pkg::atan_q30(j));
    logic signed [XW-1:0] xi, yi, zi;
    if (j == 0) begin : g_first
      assign xi = XW'(sb[K_SQ_END].c);
      assign yi = XW'(sq_root[SW-1]);
      assign zi = '0;
    end else begin : g_next
      assign xi = vx[j-1];
      assign yi = vy[j-1];
      assign zi = vz[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi >= 0) begin
          vx[j] <= xi + (yi >>> j);
          vy[j] <= yi - (xi >>> j);
          vz[j] <= zi + AT;
        end else begin
          vx[j] <= xi - (yi >>> j);
          vy[j] <= yi + (xi >>> j);
          vz[j] <= zi - AT;
        end
      end
    end
  end

  // ---------------- split the angle ----------------
  logic signed [65:0]   mprod;
  logic signed [XW-1:0] om1, ang0, ang1, a1;
  logic [IB-1:0]        t_vec;

  assign t_vec = IB'(sb[K_V_END].q.blend_t[qs_pkg::FRAC_BITS-1:0]) << (IB - qs_pkg::FRAC_BITS);
  assign a1    = XW'(mprod >>> IB);

  always_ff @(posedge clk) begin
    if (en) begin
      mprod <= 66'($signed({2'b00, t_vec}) * vz[N-1]);
      om1   <= vz[N-1];
      ang1  <= a1;
      ang0  <= om1 - a1;
    end
  end

  // ---------------- sines and weights ----------------
  logic signed [XW-1:0] sin0, sin1;
  logic signed [KW-1:0] kd0, kd1;

  qs_cordic_rot #(.STEPS(N)) u_rot0 (.clk(clk), .en(en), .angle(ang0), .sine(sin0));
  qs_cordic_rot #(.STEPS(N)) u_rot1 (.clk(clk), .en(en), .angle(ang1), .sine(sin1));

  qs_div u_div0 (.clk(clk), .en(en), .num(sin0), .den(sb[K_R_END].s), .quo(kd0));
  qs_div u_div1 (.clk(clk), .en(en), .num(sin1), .den(sb[K_R_END].s), .quo(kd1));

  // ---------------- weighted sum ----------------
  logic [IB-1:0]        t_f;
  logic signed [KW-1:0] k0, k1;
  logic signed [15:0]   av [4];
  logic signed [16:0]   bv [4];
  logic signed [PW-1:0] p0 [4];
  logic signed [PW-1:0] p1 [4];

  assign t_f = IB'(sb[K_D_END].q.blend_t[qs_pkg::FRAC_BITS-1:0]) << (IB - qs_pkg::FRAC_BITS);
  assign k0  = sb[K_D_END].lin ? (KW'(1) <<< IB) - $signed(KW'(t_f)) : kd0;
  assign k1  = sb[K_D_END].lin ? $signed(KW'(t_f)) : kd1;

  always_comb begin
    av[0] = sb[K_D_END].q.q0_w;
    av[1] = sb[K_D_END].q.q0_x;
    av[2] = sb[K_D_END].q.q0_y;
    av[3] = sb[K_D_END].q.q0_z;
    bv[0] = 17'(sb[K_D_END].q.q1_w);
    bv[1] = 17'(sb[K_D_END].q.q1_x);
    bv[2] = 17'(sb[K_D_END].q.q1_y);
    bv[3] = 17'(sb[K_D_END].q.q1_z);
    // take the shorter arc
    if (sb[K_D_END].neg) begin
      for (int j = 0; j < 4; j++) bv[j] = -bv[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        p0[j] <= PW'(k0 * av[j]);
        p1[j] <= PW'(k1 * bv[j]);
      end
    end
  end

  // ---------------- output register ----------------
  qs_pkg::out_t res;

  always_comb begin
    if (sb[K_F1].byp0) begin
      res = {sb[K_F1].q.q0_w, sb[K_F1].q.q0_x, sb[K_F1].q.q0_y, sb[K_F1].q.q0_z};
    end else if (sb[K_F1].byp1) begin
      res = {sb[K_F1].q.q1_w, sb[K_F1].q.q1_x, sb[K_F1].q.q1_y, sb[K_F1].q.q1_z};
    end else begin
      res.out_w = qs_pkg::round_sat(p0[0] + p1[0]);
      res.out_x = qs_pkg::round_sat(p0[1] + p1[1]);
      res.out_y = qs_pkg::round_sat(p0[2] + p1[2]);
      res.out_z = qs_pkg::round_sat(p0[3] + p1[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sb[K_F1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end

  // ---------------- checks ----------------
  `QS_ASSERT_NXT(a_bypass_q0, clk, rst, en && sb[K_F1].valid && sb[K_F1].byp0, out_valid && out_data.out_w == $past(sb[K_F1].q.q0_w))
  `QS_ASSERT_NXT(a_bypass_q1, clk, rst, en && sb[K_F1].valid && !sb[K_F1].byp0 && sb[K_F1].byp1, out_valid && out_data.out_x == $past(sb[K_F1].q.q1_x))
  `QS_ASSERT_IMP(a_sqrt_floor, clk, rst, sb[K_SQ_END].valid, 64'(sq_root[SW-1]) * 64'(sq_root[SW-1]) <= 64'(sq_v[SW-1]) && (64'(sq_root[SW-1]) + 64'd1) * (64'(sq_root[SW-1]) + 64'd1) > 64'(sq_v[SW-1]))

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_slerp. A directed table covers the pass
// through cases, the extremes and the arc choices. Random unit and raw
// quaternion pairs follow. Each result is compared with its typed table value
// or a bit-exact fixed-point slerp predictor; both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int     STEPS      = 16;
  localparam int     N_RANDOM   = 1500;
  localparam int     LATENCY    = 2 * STEPS + 78;
  localparam int     IDLE_LIMIT = 3000;
  localparam longint ONE_Q30    = 64'sd1 << 30;
  localparam longint ONE_Q14    = 64'sd16384;

  typedef struct {
    qs_pkg::in_t  req;
    bit           typed;
    qs_pkg::out_t want;
  } row_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_ready;
  qs_pkg::in_t  in_data;
  logic         out_valid;
  logic         out_ready;
  qs_pkg::out_t out_data;

  qs_pkg::out_t expected_q[$];
  row_t   directed[$];
  int     n_fail;
  int     n_sent;
  int     n_recv;
  int     n_pass;
  int     n_linear;
  int     n_arc;
  int     idle_cycles;
  bit     quiet;

  quaternion_slerp #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ---------------- predictor ----------------
  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan_step(int i);
    longint acc;
    longint term;
    int     e;
    acc = 0;
    if (i == 0) return 64'sd843314857;
    for (int k = 0; k < 40; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      term = (64'sd1 <<< (62 - e)) / longint'(2 * k + 1);
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    return (acc + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic longint cordic_gain_inv();
    longint unsigned p;
    longint unsigned q;
    p = 64'd1 << 30;
    for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
    q = (64'd1 << 62) / p;
    return int_sqrt(q << 28);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z;
    longint nx;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_step(i);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint rotate_sine(longint ang, longint g);
    longint x;
    longint y;
    longint nx;
    x = g;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (ang >= 0) begin
        nx  = x - (y >>> i);
        y   = y + (x >>> i);
        ang = ang - arctan_step(i);
      end else begin
        nx  = x + (y >>> i);
        y   = y - (x >>> i);
        ang = ang + arctan_step(i);
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic qs_pkg::out_t slerp_predict(qs_pkg::in_t r);
    longint qa[4];
    longint qb[4];
    longint t, dot, c, ti, k0, k1, s, g, om, a0, a1, v, res;
    logic signed [15:0] o[4];
    qa[0] = r.q0_w; qa[1] = r.q0_x; qa[2] = r.q0_y; qa[3] = r.q0_z;
    qb[0] = r.q1_w; qb[1] = r.q1_x; qb[2] = r.q1_y; qb[3] = r.q1_z;
    t = r.blend_t;
    if (t <= 0 || t >= ONE_Q14) begin
      n_pass++;
      return (t <= 0) ? qs_pkg::out_t'{r.q0_w, r.q0_x, r.q0_y, r.q0_z}
                      : qs_pkg::out_t'{r.q1_w, r.q1_x, r.q1_y, r.q1_z};
    end
    dot = 0;
    for (int j = 0; j < 4; j++) dot += qa[j] * qb[j];
    // take the shorter arc
    if (dot < 0) begin
      dot = -dot;
      for (int j = 0; j < 4; j++) qb[j] = -qb[j];
    end
    c  = dot * 4;
    ti = t * 65536;
    k0 = ONE_Q30 - ti;
    k1 = ti;
    if (c * 10000 <= 64'sd9999 * ONE_Q30) begin
      s = int_sqrt(longint'(64'd1 << 60) - c * c);
      if (s > 0) begin
        g  = cordic_gain_inv();
        om = vector_angle(c, s);
        a1 = (ti * om) >>> 30;
        a0 = om - a1;
        k0 = rotate_sine(a0, g) * ONE_Q30 / s;
        k1 = rotate_sine(a1, g) * ONE_Q30 / s;
      end
      n_arc++;
    end else begin
      n_linear++;
    end
    for (int j = 0; j < 4; j++) begin
      v   = k0 * qa[j] + k1 * qb[j];
      res = (v + (64'sd1 <<< 29)) >>> 30;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      o[j] = res[15:0];
    end
    return qs_pkg::out_t'{o[0], o[1], o[2], o[3]};
  endfunction

  // ---------------- stimulus ----------------
  function automatic qs_pkg::in_t make_req(int w0, int x0, int y0, int z0,
                                           int w1, int x1, int y1, int z1, int t);
    return qs_pkg::in_t'{16'(w0), 16'(x0), 16'(y0), 16'(z0),
                         16'(w1), 16'(x1), 16'(y1), 16'(z1), 16'(t)};
  endfunction

  task automatic add_row(qs_pkg::in_t req, bit typed, qs_pkg::out_t want);
    row_t r;
    r.req   = req;
    r.typed = typed;
    r.want  = want;
    directed.push_back(r);
  endtask

  function automatic void unit_quat(output int q[4]);
    real    v[4];
    real    n;
    n = 0.0;
    while (n < 1.0) begin
      n = 0.0;
      for (int j = 0; j < 4; j++) begin
        v[j] = real'(int'($urandom_range(0, 65535)) - 32768);
        n += v[j] * v[j];
      end
    end
    n = $sqrt(n);
    for (int j = 0; j < 4; j++) q[j] = $rtoi(v[j] / n * 16384.0);
  endfunction

  function automatic qs_pkg::in_t random_req();
    int a[4];
    int b[4];
    int t;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      return qs_pkg::in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    end
    unit_quat(a);
    if (kind < 40) begin
      // nearly equal pair, often hits the linear weights
      for (int j = 0; j < 4; j++) b[j] = a[j] + int'($urandom_range(0, 6)) - 3;
      if ($urandom_range(0, 1)) for (int j = 0; j < 4; j++) b[j] = -b[j];
    end else begin
      unit_quat(b);
    end
    if (kind < 50) t = int'($urandom_range(0, 65535)) - 32768;
    else           t = $urandom_range(1, 16383);
    return make_req(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], t);
  endfunction

  task automatic send_request(qs_pkg::in_t req, bit typed, qs_pkg::out_t want);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(typed ? want : slerp_predict(req));
    if (typed) void'(slerp_predict(req));
    n_sent++;
  endtask

  task automatic idle_gap();
    int n;
    if (quiet || $urandom_range(0, 5) != 0) return;
    n = $urandom_range(1, 19);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // ---------------- receiver ----------------
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!held && n_sent > 400) begin
        // long hold so the pipe fills and stalls the input
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------- checker and watchdog ----------------
  always @(posedge clk) begin
    qs_pkg::out_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[quaternion_slerp] ERROR");
        $finish;
      end
      if (out_valid && out_ready) begin
        n_recv++;
        if (expected_q.size() == 0) begin
          $error("result with no request pending: %h", out_data);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.out_w !== want.out_w) begin
            $error("out_w expected %0d got %0d", want.out_w, out_data.out_w);
            n_fail++;
          end
          if (out_data.out_x !== want.out_x) begin
            $error("out_x expected %0d got %0d", want.out_x, out_data.out_x);
            n_fail++;
          end
          if (out_data.out_y !== want.out_y) begin
            $error("out_y expected %0d got %0d", want.out_y, out_data.out_y);
            n_fail++;
          end
          if (out_data.out_z !== want.out_z) begin
            $error("out_z expected %0d got %0d", want.out_z, out_data.out_z);
            n_fail++;
          end
        end
      end
    end
  end

  // ---------------- main ----------------
  initial begin
    int           wait_cycles;
    qs_pkg::out_t none;
    none        = '0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    n_fail      = 0;
    n_sent      = 0;
    n_recv      = 0;
    n_pass      = 0;
    n_linear    = 0;
    n_arc       = 0;
    idle_cycles = 0;

    add_row(make_req(16384, 0, 0, 0, 123, -456, 789, -1000, 0), 1'b1,
            qs_pkg::out_t'{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    add_row(make_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768),
            1'b1, qs_pkg::out_t'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    add_row(make_req(1, 2, 3, 4, 32767, 32767, 32767, 32767, 16384), 1'b1,
            qs_pkg::out_t'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    add_row(make_req(1, 2, 3, 4, -32768, -32768, -32768, -32768, 32767), 1'b1,
            qs_pkg::out_t'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    add_row(make_req(16384, 0, 0, 0, 16384, 0, 0, 0, 1), 1'b0, none);
    add_row(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 8192), 1'b0, none);
    add_row(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 8192), 1'b0, none);
    add_row(make_req(11585, 11585, 0, 0, -11585, 0, 11585, 0, 8192), 1'b0, none);
    add_row(make_req(16384, 0, 0, 0, 15000, 6590, 0, 0, 16383), 1'b0, none);
    add_row(make_req(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 4096),
            1'b0, none);
    add_row(make_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                     8192), 1'b0, none);
    add_row(make_req(1, 0, 0, 0, 0, 1, 0, 0, 8192), 1'b0, none);
    add_row(make_req(0, 0, 0, 16384, 0, 0, 16384, 0, 12000), 1'b0, none);
    add_row(make_req(16384, 0, 0, 0, -32768, 0, 0, 0, 5000), 1'b0, none);
    add_row(make_req(0, 11585, 11585, 0, 0, 11585, 11584, 1, 10000), 1'b0, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      idle_gap();
      send_request(directed[i].req, directed[i].typed, directed[i].want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 700) begin
        // drain the pipe before carrying on
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      if (i == N_RANDOM - 200) quiet = 1'b1;
      idle_gap();
      send_request(random_req(), 1'b0, none);
    end
    @(negedge clk);
    in_valid = 1'b0;

    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 20 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      n_fail++;
    end

    $display("covered %0d requests, %0d results: %0d pass-through, %0d linear, %0d arc",
             n_sent, n_recv, n_pass, n_linear, n_arc);
    if (n_fail == 0) begin
      $display("[quaternion_slerp] OK");
    end else begin
      $display("[quaternion_slerp] ERROR");
    end
    $finish;
  end

endmodule
